FILE: hw/rtl/pfc_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// packet framer. No dependencies.
`default_nettype none

package pfc_pkg;

  // Largest payload length accepted by a start item
  localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Sync bytes at reset
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  // Frame overhead: 11 header bytes (sync included) plus 2 CRC bytes
  localparam logic [16:0] FRAME_OVERHEAD = 17'd13;

  // Commands
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // Step counter positions inside one item
  localparam logic [3:0] STEP_SYNC1     = 4'd0;
  localparam logic [3:0] STEP_SYNC2     = 4'd1;
  localparam logic [3:0] STEP_TYPE      = 4'd2;
  localparam logic [3:0] STEP_LEN_LO    = 4'd3;
  localparam logic [3:0] STEP_LEN_HI    = 4'd4;
  localparam logic [3:0] STEP_SEQ_LO    = 4'd5;
  localparam logic [3:0] STEP_SEQ_HI    = 4'd6;
  localparam logic [3:0] STEP_TS_0      = 4'd7;
  localparam logic [3:0] STEP_TS_1      = 4'd8;
  localparam logic [3:0] STEP_TS_2      = 4'd9;
  localparam logic [3:0] STEP_TS_3      = 4'd10;
  localparam logic [3:0] STEP_CRC_LO    = 4'd11;
  localparam logic [3:0] STEP_CRC_HI    = 4'd12;
  localparam logic [3:0] STEP_DATA      = 4'd0;
  localparam logic [3:0] STEP_PAY_CRCLO = 4'd1;

  // What the current beat carries
  typedef enum logic [2:0] {
    KIND_SYNC1,
    KIND_SYNC2,
    KIND_HDR,
    KIND_DATA,
    KIND_CRC_LO,
    KIND_CRC_HI,
    KIND_REJECT
  } kind_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_frame;
    logic        status;
    logic [16:0] frame_length;
  } beat_t;

  // MSB-first CRC update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pfc_apb_regs.sv
// APB register file holding the two sync bytes.
// Depends on pfc_pkg.
`default_nettype none

module pfc_apb_regs
  import pfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [7:0]       sync_first,
  output logic [7:0]       sync_second
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SYNC_FIRST:  sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux, low bits of paddr ignored
  always_comb begin
    case (paddr[2])
      REG_SYNC_FIRST:  prdata = {24'd0, sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, sync_second};
      default:         prdata = 32'd0;
    endcase
  end

  // paddr[1:0] carry no register select
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/pfc_emitter.sv
// Item register, step counter and frame state; produces one frame byte per
// beat, including header serialization and CRC. Depends on pfc_pkg.
`default_nettype none

module pfc_emitter
  import pfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  sync_first,
  input  wire logic [7:0]  sync_second,
  // item side
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        command,
  input  wire logic [7:0]  frame_type,
  input  wire logic [15:0] sequence_req,
  input  wire logic [31:0] timestamp_ms,
  input  wire logic [15:0] payload_length,
  input  wire logic [7:0]  payload_byte,
  // beat side
  output logic             beat_valid,
  input  wire logic        beat_take,
  output beat_t            beat
);

  // item held while its beats are produced
  logic        busy;
  logic [3:0]  step;
  logic        cmd;
  logic [7:0]  typ;
  logic [15:0] seq;
  logic [31:0] ts;
  logic [15:0] plen;
  logic [7:0]  pbyte;

  // frame state
  logic [15:0] crc;
  logic [15:0] remaining;
  logic        frame_open;
  logic [16:0] total_length;

  kind_t       kind;
  logic [7:0]  hdr_byte;
  logic        last_step;
  logic        fire;
  logic        item_fire;
  logic [15:0] crc_next;

  // classify the current beat
  always_comb begin
    if (cmd == CMD_START) begin
      if (plen > MAX_PAYLOAD) begin
        kind = KIND_REJECT;
      end else begin
        case (step)
          STEP_SYNC1:  kind = KIND_SYNC1;
          STEP_SYNC2:  kind = KIND_SYNC2;
          STEP_CRC_LO: kind = KIND_CRC_LO;
          STEP_CRC_HI: kind = KIND_CRC_HI;
          default:     kind = KIND_HDR;
        endcase
      end
    end else begin
      case (step)
        STEP_DATA:      kind = frame_open ? KIND_DATA : KIND_REJECT;
        STEP_PAY_CRCLO: kind = KIND_CRC_LO;
        default:        kind = KIND_CRC_HI;
      endcase
    end
  end

  // little-endian header bytes
  always_comb begin
    case (step)
      STEP_TYPE:   hdr_byte = typ;
      STEP_LEN_LO: hdr_byte = plen[7:0];
      STEP_LEN_HI: hdr_byte = plen[15:8];
      STEP_SEQ_LO: hdr_byte = seq[7:0];
      STEP_SEQ_HI: hdr_byte = seq[15:8];
      STEP_TS_0:   hdr_byte = ts[7:0];
      STEP_TS_1:   hdr_byte = ts[15:8];
      STEP_TS_2:   hdr_byte = ts[23:16];
      STEP_TS_3:   hdr_byte = ts[31:24];
      default:     hdr_byte = 8'd0;
    endcase
  end

  // beat contents and end-of-item detection
  always_comb begin
    beat.out_byte      = 8'd0;
    beat.last_of_frame = 1'b0;
    beat.status        = 1'b0;
    beat.frame_length  = 17'd0;
    last_step          = 1'b0;
    crc_next           = crc;
    case (kind)
      KIND_SYNC1: beat.out_byte = sync_first;
      KIND_SYNC2: beat.out_byte = sync_second;
      KIND_HDR: begin
        beat.out_byte = hdr_byte;
        crc_next      = crc_byte(crc, hdr_byte);
        last_step     = (step == STEP_TS_3) && (plen != 16'd0);
      end
      KIND_DATA: begin
        beat.out_byte = pbyte;
        crc_next      = crc_byte(crc, pbyte);
        last_step     = (remaining > 16'd1);
      end
      KIND_CRC_LO: beat.out_byte = crc[7:0];
      KIND_CRC_HI: begin
        beat.out_byte      = crc[15:8];
        beat.last_of_frame = 1'b1;
        beat.frame_length  = total_length;
        last_step          = 1'b1;
      end
      KIND_REJECT: begin
        beat.last_of_frame = 1'b1;
        beat.status        = 1'b1;
        last_step          = 1'b1;
      end
      default: ;
    endcase
  end

  assign beat_valid = busy;
  assign fire       = busy & beat_take;
  assign item_ready = ~busy | (fire & last_step);
  assign item_fire  = item_valid & item_ready;

  // control: busy flag and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else begin
      if (item_fire) begin
        busy <= 1'b1;
        step <= 4'd0;
      end else if (fire) begin
        if (last_step) begin
          busy <= 1'b0;
          step <= 4'd0;
        end else begin
          step <= step + 4'd1;
        end
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (item_fire) begin
      cmd   <= command;
      typ   <= frame_type;
      seq   <= sequence_req;
      ts    <= timestamp_ms;
      plen  <= payload_length;
      pbyte <= payload_byte;
    end
  end

  // frame state updates, one per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      crc          <= CRC_INIT;
      remaining    <= 16'd0;
      frame_open   <= 1'b0;
      total_length <= 17'd0;
    end else if (fire) begin
      case (kind)
        KIND_SYNC1: begin
          crc          <= CRC_INIT;
          remaining    <= 16'd0;
          frame_open   <= 1'b0;
          total_length <= 17'd0;
        end
        KIND_REJECT: begin
          // a rejected start still abandons any open frame
          if (cmd == CMD_START) begin
            crc          <= CRC_INIT;
            remaining    <= 16'd0;
            frame_open   <= 1'b0;
            total_length <= 17'd0;
          end
        end
        KIND_HDR: begin
          crc <= crc_next;
          if (step == STEP_TS_3) begin
            total_length <= {1'b0, plen} + FRAME_OVERHEAD;
            remaining    <= plen;
            frame_open   <= 1'b1;
          end
        end
        KIND_DATA: begin
          crc <= crc_next;
          if (remaining != 16'd0) begin
            remaining <= remaining - 16'd1;
          end
        end
        KIND_CRC_HI: begin
          crc        <= CRC_INIT;
          remaining  <= 16'd0;
          frame_open <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pfc_out_reg.sv
// Output register for result beats; loads whenever empty or being drained.
// Depends on pfc_pkg.
`default_nettype none

module pfc_out_reg
  import pfc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  beat_valid,
  output logic       beat_take,
  input  wire beat_t beat,
  output logic       result_valid,
  input  wire logic  result_ready,
  output beat_t      result
);

  assign beat_take = ~result_valid | result_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (beat_take) begin
      result_valid <= beat_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (beat_take & beat_valid) begin
      result <= beat;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/packet_framer_crc16_core.sv
// Packet framer with CRC-16/CCITT-FALSE, top level.
// Depends on pfc_pkg, pfc_apb_regs, pfc_emitter, pfc_out_reg.
//
//  Channel  | Handshake                      | Beat contents
//  ---------+--------------------------------+--------------------------------
//  item     | item_valid / item_ready        | command, header fields, byte
//  result   | result_valid / result_ready    | out_byte, last_of_frame,
//           |                                | status, frame_length
//  config   | APB psel/penable/pwrite/pready | sync_first @0, sync_second @4
//
// One result beat leaves per cycle while result_ready is high. Per item the
// emitter's step counter gives one data beat (payload) or the sync and header
// beats (start), plus the CRC beats when closing the frame, or one reject beat.
// A new item is taken in the cycle its last beat moves to the output register.
// A stall on result_ready freezes the emitter; rst is synchronous.
`default_nettype none

module packet_framer_crc16_core
  import pfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // items
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        command,
  input  wire logic [7:0]  frame_type,
  input  wire logic [15:0] sequence_req,
  input  wire logic [31:0] timestamp_ms,
  input  wire logic [15:0] payload_length,
  input  wire logic [7:0]  payload_byte,
  // results
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_frame,
  output logic             status,
  output logic [16:0]      frame_length
);

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic       beat_valid;
  logic       beat_take;
  beat_t      beat;
  beat_t      result;

  pfc_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .sync_first  (sync_first),
    .sync_second (sync_second)
  );

  pfc_emitter u_emit (
    .clk            (clk),
    .rst            (rst),
    .sync_first     (sync_first),
    .sync_second    (sync_second),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .command        (command),
    .frame_type     (frame_type),
    .sequence_req   (sequence_req),
    .timestamp_ms   (timestamp_ms),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .beat_valid     (beat_valid),
    .beat_take      (beat_take),
    .beat           (beat)
  );

  pfc_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .beat_valid   (beat_valid),
    .beat_take    (beat_take),
    .beat         (beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign out_byte      = result.out_byte;
  assign last_of_frame = result.last_of_frame;
  assign status        = result.status;
  assign frame_length  = result.frame_length;

endmodule

`default_nettype wire
